@@ hdl/lkv_pkg.sv @@
// ---------------------------------------------------------------------------
// lkv_pkg: shared constants for the LRU key/value cache
// Request mode codes, configuration register map and APB widths.
// ---------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  localparam int unsigned MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROBE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // One register at byte address 0; one more index bit so that writes
  // beyond the map decode to an unused index.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

  localparam int unsigned   CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

endpackage

`default_nettype wire

@@ hdl/lkv_req_if.sv @@
// ---------------------------------------------------------------------------
// lkv_req_if: request channel of the LRU key/value cache
// Valid/ready channel carrying mode, key and value of one item.
// ---------------------------------------------------------------------------
`default_nettype none

interface lkv_req_if #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) ();
  logic                      valid;
  logic                      ready;
  logic [lkv_pkg::MODE_W-1:0] mode;
  logic [KEY_BITS-1:0]       key;
  logic [VALUE_BITS-1:0]     value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/lkv_rsp_if.sv @@
// ---------------------------------------------------------------------------
// lkv_rsp_if: response channel of the LRU key/value cache
// Valid/ready channel carrying hit, read value and eviction report.
// ---------------------------------------------------------------------------
`default_nettype none

interface lkv_rsp_if #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

`default_nettype wire

@@ hdl/lru_key_value_cache.sv @@
// ---------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with LRU replacement
// Lookup, probe and insert over ENTRIES slots; keys and values in RAM,
// valid bits and recency ranks in flip-flops.
// ---------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_i     in         valid/ready        mode, key, value
//  rsp_o     out        valid/ready        hit, read_value, evicted, evicted_key
//  apb       in         psel/penable       capacity register at address 0
//
//  The cache takes a new item only once the last one has finished:
//  the key RAM has one read port, so the scan reads one slot per cycle,
//  followed by last-compare, decide, apply and result states.
//  After reset the cache is empty and the capacity is 16.
//  A result waits in the output register; a stalled output holds the next
//  item in its final cycle until the register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  lkv_req_if.sink                             req_i,
  lkv_rsp_if.source                           rsp_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lkv_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lkv_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lkv_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > lkv_pkg::CAP_BITS) ? CntW : lkv_pkg::CAP_BITS;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_LAST   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_APPLY  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [lkv_pkg::CAP_BITS-1:0] cap;
  logic [CmpW-1:0]              cap_w;
  logic [CmpW-1:0]              cap_eff;

  lkv_apb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  // Key and value storage
  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [KEY_BITS-1:0]   key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic [IdxW-1:0]       rd_addr;
  logic [IdxW-1:0]       wr_addr;
  logic                  key_we;
  logic                  val_we;

  // Control and bookkeeping
  logic [2:0]                  state_q, state_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic                        cmp_v_q, cmp_v_d;
  logic [IdxW-1:0]             cmp_idx_q, cmp_idx_d;
  logic [lkv_pkg::MODE_W-1:0]  mode_q, mode_d;
  logic [KEY_BITS-1:0]         key_q, key_d;
  logic [VALUE_BITS-1:0]       value_q, value_d;
  logic                        found_q, found_d;
  logic [IdxW-1:0]             found_idx_q, found_idx_d;
  logic                        free_v_q, free_v_d;
  logic [IdxW-1:0]             free_idx_q, free_idx_d;
  logic                        old_v_q, old_v_d;
  logic [IdxW-1:0]             old_idx_q, old_idx_d;
  logic [IdxW-1:0]             old_rank_q, old_rank_d;
  logic                        evict_q, evict_d;
  logic [ENTRIES-1:0]          valid_q, valid_d;
  logic [IdxW-1:0]             rank_q [ENTRIES];
  logic [IdxW-1:0]             rank_d [ENTRIES];
  logic [CntW-1:0]             count_q, count_d;
  logic [IdxW-1:0]             found_rank;
  logic [IdxW-1:0]             ins_slot;

  logic                  res_hit_q, res_hit_d;
  logic [VALUE_BITS-1:0] res_rd_q, res_rd_d;
  logic                  res_ev_q, res_ev_d;
  logic [KEY_BITS-1:0]   res_evk_q, res_evk_d;

  logic                  rsp_valid_q, rsp_valid_d;
  logic                  rsp_hit_q, rsp_hit_d;
  logic [VALUE_BITS-1:0] rsp_rd_q, rsp_rd_d;
  logic                  rsp_ev_q, rsp_ev_d;
  logic [KEY_BITS-1:0]   rsp_evk_q, rsp_evk_d;

  assign cap_w = CmpW'(cap);

  always_comb begin
    cap_eff = cap_w;
    if (cap_w == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_w > CmpW'(ENTRIES)) begin
      cap_eff = CmpW'(ENTRIES);
    end
  end

  assign found_rank = rank_q[found_idx_q];

  // The new entry goes into the lowest free slot once the victim is gone.
  assign ins_slot = (evict_q && (!free_v_q || (old_idx_q < free_idx_q))) ? old_idx_q
                                                                         : free_idx_q;

  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    mode_d      = mode_q;
    key_d       = key_q;
    value_d     = value_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    free_v_d    = free_v_q;
    free_idx_d  = free_idx_q;
    old_v_d     = old_v_q;
    old_idx_d   = old_idx_q;
    old_rank_d  = old_rank_q;
    evict_d     = evict_q;
    valid_d     = valid_q;
    rank_d      = rank_q;
    count_d     = count_q;
    rd_addr     = idx_q;
    wr_addr     = found_idx_q;
    key_we      = 1'b0;
    val_we      = 1'b0;
    res_hit_d   = res_hit_q;
    res_rd_d    = res_rd_q;
    res_ev_d    = res_ev_q;
    res_evk_d   = res_evk_q;
    rsp_valid_d = rsp_valid_q & ~rsp_o.ready;
    rsp_hit_d   = rsp_hit_q;
    rsp_rd_d    = rsp_rd_q;
    rsp_ev_d    = rsp_ev_q;
    rsp_evk_d   = rsp_evk_q;

    // Key compare on the registered read data, in the cycle after the read address; the first match wins.
    if (cmp_v_q && valid_q[cmp_idx_q] && (key_rd_q == key_q) && !found_q) begin
      found_d     = 1'b1;
      found_idx_d = cmp_idx_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          mode_d   = req_i.mode;
          key_d    = req_i.key;
          value_d  = req_i.value;
          idx_d    = '0;
          found_d  = 1'b0;
          free_v_d = 1'b0;
          old_v_d  = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr   = idx_q;
        cmp_v_d   = 1'b1;
        cmp_idx_d = idx_q;
        if (valid_q[idx_q]) begin
          if (!old_v_q || (rank_q[idx_q] > old_rank_q)) begin
            old_v_d    = 1'b1;
            old_idx_d  = idx_q;
            old_rank_d = rank_q[idx_q];
          end
        end else if (!free_v_q) begin
          free_v_d   = 1'b1;
          free_idx_d = idx_q;
        end
        if (idx_q == LastIdx) begin
          state_d = ST_LAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_LAST: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        evict_d = (mode_q == lkv_pkg::MODE_INSERT) && !found_q && old_v_q &&
                  (CmpW'(count_q) >= cap_eff);
        rd_addr = (mode_q == lkv_pkg::MODE_LOOKUP) ? found_idx_q : old_idx_q;
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        res_hit_d = found_q && (mode_q != lkv_pkg::MODE_UNUSED);
        res_rd_d  = (found_q && (mode_q == lkv_pkg::MODE_LOOKUP)) ? val_rd_q : '0;
        res_ev_d  = evict_q;
        res_evk_d = evict_q ? key_rd_q : '0;
        if (found_q && ((mode_q == lkv_pkg::MODE_LOOKUP) ||
                        (mode_q == lkv_pkg::MODE_INSERT))) begin
          // Entries more recent than the hit age by one.
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && (IdxW'(i) != found_idx_q) && (rank_q[i] < found_rank)) begin
              rank_d[i] = rank_q[i] + 1'b1;
            end
          end
          rank_d[found_idx_q] = '0;
          if (mode_q == lkv_pkg::MODE_INSERT) begin
            val_we  = 1'b1;
            wr_addr = found_idx_q;
          end
        end else if (!found_q && (mode_q == lkv_pkg::MODE_INSERT)) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && !(evict_q && (IdxW'(i) == old_idx_q))) begin
              rank_d[i] = rank_q[i] + 1'b1;
            end
          end
          if (evict_q) begin
            valid_d[old_idx_q] = 1'b0;
          end else begin
            count_d = count_q + 1'b1;
          end
          valid_d[ins_slot] = 1'b1;
          rank_d[ins_slot]  = '0;
          key_we  = 1'b1;
          val_we  = 1'b1;
          wr_addr = ins_slot;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_hit_d   = res_hit_q;
          rsp_rd_d    = res_rd_q;
          rsp_ev_d    = res_ev_q;
          rsp_evk_d   = res_evk_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    if (val_we) begin
      val_mem[wr_addr] <= value_q;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_v_q     <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cmp_v_q     <= cmp_v_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      rank_q      <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    cmp_idx_q   <= cmp_idx_d;
    mode_q      <= mode_d;
    key_q       <= key_d;
    value_q     <= value_d;
    found_q     <= found_d;
    found_idx_q <= found_idx_d;
    free_v_q    <= free_v_d;
    free_idx_q  <= free_idx_d;
    old_v_q     <= old_v_d;
    old_idx_q   <= old_idx_d;
    old_rank_q  <= old_rank_d;
    evict_q     <= evict_d;
    res_hit_q   <= res_hit_d;
    res_rd_q    <= res_rd_d;
    res_ev_q    <= res_ev_d;
    res_evk_q   <= res_evk_d;
    rsp_hit_q   <= rsp_hit_d;
    rsp_rd_q    <= rsp_rd_d;
    rsp_ev_q    <= rsp_ev_d;
    rsp_evk_q   <= rsp_evk_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.hit         = rsp_hit_q;
  assign rsp_o.read_value  = rsp_rd_q;
  assign rsp_o.evicted     = rsp_ev_q;
  assign rsp_o.evicted_key = rsp_evk_q;

endmodule

`default_nettype wire

@@ hdl/lkv_apb_cfg.sv @@
// ---------------------------------------------------------------------------
// lkv_apb_cfg: APB configuration register block
// Holds the capacity register; writes complete in the access phase.
// ---------------------------------------------------------------------------
`default_nettype none

module lkv_apb_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lkv_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lkv_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lkv_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  output logic      [lkv_pkg::CAP_BITS-1:0]   cap_o
);

  logic [lkv_pkg::CAP_BITS-1:0]  cap_q;
  logic [lkv_pkg::CAP_BITS-1:0]  cap_d;
  logic [lkv_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lkv_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cap_d = cap_q;
    if (wr_en && (reg_idx == lkv_pkg::REG_CAPACITY)) begin
      cap_d = pwdata[lkv_pkg::CAP_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == lkv_pkg::REG_CAPACITY) begin
      prdata = {{(lkv_pkg::APB_DATA_W - lkv_pkg::CAP_BITS){1'b0}}, cap_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkv_pkg::CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign cap_o = cap_q;

endmodule

`default_nettype wire

@@ hdl/lkv_checker.sv @@
// ---------------------------------------------------------------------------
// lkv_checker: port-level checks for the LRU key/value cache
// Watches the request and response channels and the result fields.
// ---------------------------------------------------------------------------
`default_nettype none

module lkv_checker #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  req_valid_i,
  input wire logic                  req_ready_i,
  input wire logic                  rsp_valid_i,
  input wire logic                  rsp_ready_i,
  input wire logic                  rsp_hit_i,
  input wire logic [VALUE_BITS-1:0] rsp_read_value_i,
  input wire logic                  rsp_evicted_i,
  input wire logic [KEY_BITS-1:0]   rsp_evicted_key_i
);

  // The cache works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while an item is in progress");

  // Only a hit can return a stored value.
  a_value_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_hit_i) |-> (rsp_read_value_i == '0))
    else $error("read value without a hit");

  // An insert of a present key updates in place and never evicts.
  a_evict_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_evicted_i) |-> !rsp_hit_i)
    else $error("eviction reported together with a hit");

  a_evict_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_evicted_i) |-> (rsp_evicted_key_i == '0))
    else $error("evicted key without an eviction");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_evicted_key_i)))
    else $error("stalled response item changed");

endmodule

bind lru_key_value_cache lkv_checker #(
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_lkv_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_hit_i         (rsp_o.hit),
  .rsp_read_value_i  (rsp_o.read_value),
  .rsp_evicted_i     (rsp_o.evicted),
  .rsp_evicted_key_i (rsp_o.evicted_key)
);

`default_nettype wire
